// ===== hdl/lobm_pkg.sv =====
// lobm_pkg: shared types and constants for the limit order book matcher
// no dependencies
`timescale 1ns / 1ps
package lobm_pkg;

	localparam int ORDER_SLOTS = 32;
	localparam int CLIENTS = 16;
	localparam int CLIENT_ORDER_IDS = 1024;
	localparam int SLOT_W = $clog2(ORDER_SLOTS);
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		KIND_ACCEPTED = 3'd0,
		KIND_FILL = 3'd1,
		KIND_RESTED = 3'd2,
		KIND_CANCELED = 3'd3,
		KIND_CANCEL_REJ = 3'd4,
		KIND_DROPPED = 3'd5
	} kind_t;

	localparam logic ACT_ADD = 1'b0;
	localparam logic ACT_CANCEL = 1'b1;
	localparam logic SIDE_BUY = 1'b0;

	typedef struct packed {
		logic action;
		logic [3:0] trader;
		logic [9:0] trader_ref;
		logic side;
		logic [15:0] price;
		logic [15:0] quantity;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] trader_res;
		logic [9:0] trader_ref_res;
		logic [31:0] market_order_id;
		logic side_res;
		logic [15:0] price_res;
		logic [15:0] traded_qty;
		logic [15:0] open_qty;
		logic [3:0] resting_trader;
		logic [9:0] resting_trader_ref;
		logic [15:0] resting_open_qty;
		logic last;
	} out_item_t;

	// classified command passed from front to back
	typedef struct packed {
		in_item_t item;
		logic key_ok;
		logic [31:0] mid;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_EMIT,
		ST_FREE
	} eng_state_t;

endpackage

// ===== hdl/lobm_front.sv =====
// lobm_front: accepts beats, assigns market ids, checks cancel keys, queues commands
// depends on lobm_pkg
`timescale 1ns / 1ps
module lobm_front
	import lobm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic cmd_valid,
	input logic cmd_ready,
	output cmd_t cmd_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t fifo_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0] count_q;
	logic [31:0] next_mid_q;
	logic push, pop;

	assign in_ready = (count_q != (PW+1)'(QUEUE_DEPTH));
	assign push = in_valid && in_ready;
	assign pop = cmd_valid && cmd_ready;
	assign cmd_valid = (count_q != '0);
	assign cmd_data = fifo_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].item <= in_data;
			fifo_q[wr_ptr_q].mid <= next_mid_q;
			fifo_q[wr_ptr_q].key_ok <= (32'(in_data.trader) < 32'(CLIENTS)) &&
				(32'(in_data.trader_ref) < 32'(CLIENT_ORDER_IDS));
		end
	end

	// pointers and id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
			next_mid_q <= 32'd1;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
				if (in_data.action == ACT_ADD) next_mid_q <= next_mid_q + 32'd1;
			end
			if (pop) rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == (PW+1)'(QUEUE_DEPTH) |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> !pop) else $error("queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

// ===== hdl/lobm_engine.sv =====
// lobm_engine: order table and matching sequencer, one slot examined per cycle
// depends on lobm_pkg
`timescale 1ns / 1ps
module lobm_engine
	import lobm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input cmd_t cmd_data,
	output logic res_valid,
	input logic res_ready,
	output out_item_t res_data
);

	// table; valid bits in flops, payload undefined until written
	logic [ORDER_SLOTS-1:0] slot_valid_q;
	logic [31:0] s_mid_q [ORDER_SLOTS];
	logic [3:0] s_cid_q [ORDER_SLOTS];
	logic [9:0] s_coid_q [ORDER_SLOTS];
	logic s_side_q [ORDER_SLOTS];
	logic [15:0] s_price_q [ORDER_SLOTS];
	logic [15:0] s_qty_q [ORDER_SLOTS];
	logic [15:0] s_arr_q [ORDER_SLOTS];

	eng_state_t state_q, state_d;
	cmd_t cmd_q;
	logic [15:0] leaves_q;
	logic [15:0] arrival_q;
	logic [SLOT_W:0] idx_q;
	logic best_found_q;
	logic [SLOT_W-1:0] best_q;
	logic [15:0] best_price_q, best_age_q;
	logic accepted_done_q;
	out_item_t out_q;
	logic out_valid_q;

	logic [SLOT_W-1:0] idx;
	logic [15:0] age;
	logic cand, better;
	logic [15:0] rq, fq, new_leaves;
	logic out_free;

	assign idx = idx_q[SLOT_W-1:0];
	assign age = arrival_q - s_arr_q[idx];
	assign out_free = !out_valid_q || res_ready;
	assign res_valid = out_valid_q;
	assign res_data = out_q;
	assign cmd_ready = (state_q == ST_IDLE) && !out_valid_q;

	// candidate test for the current slot
	always_comb begin
		cand = 1'b0;
		better = 1'b0;
		if (cmd_q.item.action == ACT_ADD) begin
			cand = slot_valid_q[idx] && (s_side_q[idx] != cmd_q.item.side) &&
				((cmd_q.item.side == SIDE_BUY) ? (s_price_q[idx] <= cmd_q.item.price)
					: (s_price_q[idx] >= cmd_q.item.price));
			better = !best_found_q ||
				((cmd_q.item.side == SIDE_BUY) ? (s_price_q[idx] < best_price_q)
					: (s_price_q[idx] > best_price_q)) ||
				(s_price_q[idx] == best_price_q && age > best_age_q);
		end else begin
			cand = cmd_q.key_ok && slot_valid_q[idx] && s_cid_q[idx] == cmd_q.item.trader
				&& s_coid_q[idx] == cmd_q.item.trader_ref;
			better = !best_found_q || age < best_age_q;
		end
		rq = s_qty_q[best_q];
		fq = (leaves_q < rq) ? leaves_q : rq;
		new_leaves = leaves_q - fq;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd_valid && cmd_ready) state_d = ST_SCAN;
			ST_SCAN: if (idx_q == (SLOT_W+1)'(ORDER_SLOTS-1)) state_d = ST_DECIDE;
			ST_DECIDE: if (out_free) begin
				if (cmd_q.item.action == ACT_CANCEL) state_d = ST_IDLE;
				else if (!accepted_done_q) state_d = (leaves_q == '0) ? ST_IDLE : ST_DECIDE;
				else if (best_found_q && leaves_q != '0) state_d = ST_EMIT;
				else if (leaves_q != '0) state_d = ST_FREE;
				else state_d = ST_IDLE;
			end
			ST_EMIT: if (out_free) state_d = (new_leaves == '0) ? ST_IDLE : ST_SCAN;
			ST_FREE: if (out_free && (!slot_valid_q[idx] || idx_q == (SLOT_W+1)'(ORDER_SLOTS-1)))
				state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// datapath and table updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			arrival_q <= '0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			best_found_q <= 1'b0;
			accepted_done_q <= 1'b0;
		end else begin
			if (out_valid_q && res_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (cmd_valid && cmd_ready) begin
					cmd_q <= cmd_data;
					leaves_q <= cmd_data.item.quantity;
					idx_q <= '0;
					best_found_q <= 1'b0;
					accepted_done_q <= (cmd_data.item.action == ACT_CANCEL);
				end
				ST_SCAN: begin
					if (cand && better) begin
						best_found_q <= 1'b1;
						best_q <= idx;
						best_price_q <= s_price_q[idx];
						best_age_q <= age;
					end
					idx_q <= idx_q + (SLOT_W+1)'(1);
				end
				ST_DECIDE: if (out_free) begin
					out_valid_q <= 1'b1;
					out_q <= '0;
					out_q.trader_res <= cmd_q.item.trader;
					out_q.trader_ref_res <= cmd_q.item.trader_ref;
					if (cmd_q.item.action == ACT_CANCEL) begin
						out_q.last <= 1'b1;
						if (best_found_q) begin
							out_q.kind <= KIND_CANCELED;
							out_q.market_order_id <= s_mid_q[best_q];
							out_q.side_res <= s_side_q[best_q];
							out_q.price_res <= s_price_q[best_q];
							out_q.open_qty <= s_qty_q[best_q];
							slot_valid_q[best_q] <= 1'b0;
						end else begin
							out_q.kind <= KIND_CANCEL_REJ;
						end
					end else if (!accepted_done_q) begin
						out_q.kind <= KIND_ACCEPTED;
						out_q.market_order_id <= cmd_q.mid;
						out_q.side_res <= cmd_q.item.side;
						out_q.price_res <= cmd_q.item.price;
						out_q.open_qty <= leaves_q;
						out_q.last <= (leaves_q == '0);
						accepted_done_q <= 1'b1;
					end else begin
						out_valid_q <= 1'b0;
						idx_q <= '0;
					end
				end
				ST_EMIT: if (out_free) begin
					out_valid_q <= 1'b1;
					out_q <= '0;
					out_q.kind <= KIND_FILL;
					out_q.trader_res <= cmd_q.item.trader;
					out_q.trader_ref_res <= cmd_q.item.trader_ref;
					out_q.market_order_id <= s_mid_q[best_q];
					out_q.side_res <= cmd_q.item.side;
					out_q.price_res <= s_price_q[best_q];
					out_q.traded_qty <= fq;
					out_q.open_qty <= new_leaves;
					out_q.resting_trader <= s_cid_q[best_q];
					out_q.resting_trader_ref <= s_coid_q[best_q];
					out_q.resting_open_qty <= rq - fq;
					out_q.last <= (new_leaves == '0);
					s_qty_q[best_q] <= rq - fq;
					if (rq == fq) slot_valid_q[best_q] <= 1'b0;
					leaves_q <= new_leaves;
					idx_q <= '0;
					best_found_q <= 1'b0;
				end
				ST_FREE: if (out_free) begin
					if (!slot_valid_q[idx] || idx_q == (SLOT_W+1)'(ORDER_SLOTS-1)) begin
						out_valid_q <= 1'b1;
						out_q <= '0;
						out_q.trader_res <= cmd_q.item.trader;
						out_q.trader_ref_res <= cmd_q.item.trader_ref;
						out_q.market_order_id <= cmd_q.mid;
						out_q.side_res <= cmd_q.item.side;
						out_q.price_res <= cmd_q.item.price;
						out_q.open_qty <= leaves_q;
						out_q.last <= 1'b1;
						if (!slot_valid_q[idx]) begin
							out_q.kind <= KIND_RESTED;
							slot_valid_q[idx] <= 1'b1;
							s_mid_q[idx] <= cmd_q.mid;
							s_cid_q[idx] <= cmd_q.item.trader;
							s_coid_q[idx] <= cmd_q.item.trader_ref;
							s_side_q[idx] <= cmd_q.item.side;
							s_price_q[idx] <= cmd_q.item.price;
							s_qty_q[idx] <= leaves_q;
							s_arr_q[idx] <= arrival_q;
							arrival_q <= arrival_q + 16'd1;
						end else begin
							out_q.kind <= KIND_DROPPED;
						end
					end else begin
						idx_q <= idx_q + (SLOT_W+1)'(1);
					end
				end
				default: ;
			endcase
		end
	end

	a_fill_has_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> best_found_q && slot_valid_q[best_q])
		else $error("fill without resting order");
	a_idle_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> state_q == ST_SCAN) else $error("command not started");
	a_fill_qty_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_FILL |-> out_q.traded_qty != '0)
		else $error("empty fill");

endmodule

// ===== hdl/limit_order_book_matcher_unit.sv =====
// limit_order_book_matcher_unit: top level, front queue feeding the matching engine
// depends on lobm_pkg, lobm_front, lobm_engine
//
// channel | direction | handshake               | payload
// in      | input     | in_valid / in_ready     | in_data (in_item_t)
// out     | output    | out_valid / out_ready   | out_data (out_item_t)
//
// the engine takes a command once its output register is empty, then scans the
// table one slot per cycle, then decides. a cancel ends after that decide; an add
// spends an extra decide on its accept result, one emit step per fill, a new scan
// and decide after each fill that leaves quantity, and a free-slot walk over up to
// ORDER_SLOTS slots to rest.
// reset clears the table valid bits at once; no clearing pass.
// out_ready stalls hold the engine; the front queue keeps accepting up to QUEUE_DEPTH beats.
`timescale 1ns / 1ps
module limit_order_book_matcher_unit
	import lobm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data
);

	logic cmd_valid, cmd_ready;
	cmd_t cmd_data;

	lobm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data)
	);

	lobm_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
		.res_valid(out_valid), .res_ready(out_ready), .res_data(out_data)
	);

endmodule
